// ----- hdl/spb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and constants of the servo position packet builder.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int unsigned DEF_NUM_SERVOS = 6;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
  localparam logic [POS_W-1:0] POS_RESET  = 10'd512;
  localparam logic [POS_W-1:0] STEP_RESET = 10'd10;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] PKT_LENGTH    = 8'h07;
  localparam logic [7:0] INSTR_WRITE   = 8'h03;
  localparam logic [7:0] ADDR_GOAL_POS = 8'h1E;

  typedef enum logic [1:0] {
    DIR_REVERSE  = 2'd0,
    DIR_HOLD     = 2'd1,
    DIR_FORWARD  = 2'd2,
    DIR_HOLD_ALT = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    IDX_HDR0   = 4'd0,
    IDX_HDR1   = 4'd1,
    IDX_ID     = 4'd2,
    IDX_LEN    = 4'd3,
    IDX_INSTR  = 4'd4,
    IDX_ADDR   = 4'd5,
    IDX_POS_LO = 4'd6,
    IDX_POS_HI = 4'd7,
    IDX_SPD_LO = 4'd8,
    IDX_SPD_HI = 4'd9,
    IDX_CHK    = 4'd10
  } pkt_idx_e;

  typedef struct packed {
    logic [7:0] servo_id;
    logic [1:0] direction;
    logic [9:0] speed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       bad_id;
  } out_item_t;

  typedef struct packed {
    logic             bad;
    logic [7:0]       id;
    logic [POS_W-1:0] pos;
    logic [9:0]       spd;
    logic [7:0]       chk;
  } pkt_t;

endpackage

// ----- hdl/servo_position_packet_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_packet_builder_core
// Keeps a goal position per servo and builds the write packet for each command.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o, payload in_item_i (id, direction,
//                 speed); a transaction is taken when valid is high and stall low
//   out channel : out_valid_o / out_stall_i, payload out_item_o; one packet
//                 byte per transaction, last_byte set on the checksum byte
//   cfg channel : cfg_valid_i / cfg_ready_o, cfg_data_i sets the position step;
//                 ready is always high, write only while the block is idle
//   order       : a taken command is registered in the input stage, then loaded
//                 into the packet register, whose bytes the one-byte output
//                 serializer sends; the next command waits in the input stage
//                 and moves into the packet register as the last byte leaves
//   bad id      : id 0 or above NUM_SERVOS gives one result, byte 0, last and
//                 bad_id set, and changes no goal position
//   reset       : all goal positions read 512 and the step is 10 at once,
//                 through per-entry valid bits; no clearing pass
//   stall       : a stalled byte holds; the input stage fills and then stalls
// ----------------------------------------------------------------------------
module servo_position_packet_builder_core #(
  parameter int unsigned NUM_SERVOS = spb_pkg::DEF_NUM_SERVOS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [spb_pkg::POS_W-1:0] cfg_data_i
);
  import spb_pkg::*;

  localparam int unsigned AW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [7:0] ID_MAX = 8'(NUM_SERVOS);

  logic             a_valid_q;
  in_item_t         a_q;
  logic [POS_W-1:0] step_q;

  logic             in_accept;
  logic             a_adv;
  logic             ser_free;
  logic [7:0]       in_idx;
  logic [7:0]       a_idx;
  logic             a_bad;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] new_pos;
  logic [POS_W:0]   pos_sum;
  logic [7:0]       sum8;
  pkt_t             pkt;

  assign cfg_ready_o = 1'b1;

  assign a_adv      = a_valid_q && ser_free;
  assign in_stall_o = a_valid_q && !a_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      step_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= in_item_i;
    end
  end

  assign in_idx = in_item_i.servo_id - 8'd1;
  assign a_idx  = a_q.servo_id - 8'd1;
  assign a_bad  = (a_q.servo_id == 8'd0) || (a_q.servo_id > ID_MAX);

  spb_goal_mem #(
    .NUM_SERVOS(NUM_SERVOS),
    .AW        (AW)
  ) u_goal_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_addr_i(in_idx[AW-1:0]),
    .rd_data_o(cur_pos),
    .wr_en_i  (a_adv && !a_bad),
    .wr_addr_i(a_idx[AW-1:0]),
    .wr_data_i(new_pos)
  );

  // step and clamp
  assign pos_sum = {1'b0, cur_pos} + {1'b0, step_q};

  always_comb begin
    case (a_q.direction) inside
      DIR_REVERSE: new_pos = (cur_pos >= step_q) ? (cur_pos - step_q) : '0;
      DIR_FORWARD: new_pos = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
      DIR_HOLD, DIR_HOLD_ALT: new_pos = cur_pos;
      default:     new_pos = cur_pos;
    endcase
  end

  assign sum8 = a_q.servo_id + PKT_LENGTH + INSTR_WRITE + ADDR_GOAL_POS
              + new_pos[7:0] + {6'd0, new_pos[9:8]}
              + a_q.speed[7:0] + {6'd0, a_q.speed[9:8]};

  assign pkt.bad = a_bad;
  assign pkt.id  = a_q.servo_id;
  assign pkt.pos = new_pos;
  assign pkt.spd = a_q.speed;
  assign pkt.chk = HDR_BYTE - sum8;

  spb_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (a_adv),
    .pkt_i      (pkt),
    .free_o     (ser_free),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_adv) |=> a_valid_q)
    else $error("pending command dropped");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> out_valid_o)
    else $error("loaded packet not offered");

  a_hold_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_bad &&
     (a_q.direction == DIR_HOLD || a_q.direction == DIR_HOLD_ALT))
      |-> (new_pos == cur_pos))
    else $error("hold command moved the goal");
`endif

endmodule

// ----- hdl/spb_goal_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_goal_mem
// Goal position store, one entry per servo, registered read with write
// forwarding; entries not yet written read as the reset position.
// ----------------------------------------------------------------------------
module spb_goal_mem #(
  parameter int unsigned NUM_SERVOS = spb_pkg::DEF_NUM_SERVOS,
  parameter int unsigned AW         = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [spb_pkg::POS_W-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [spb_pkg::POS_W-1:0] wr_data_i
);
  import spb_pkg::*;

  logic [POS_W-1:0]      mem [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] valid_q;
  logic [POS_W-1:0]      rd_q;
  logic                  rd_valid_q;
  logic                  fwd;

  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (fwd) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= fwd || valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : POS_RESET;

`ifndef SYNTH
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (int'(wr_addr_i) < NUM_SERVOS))
    else $error("goal write address out of range");

  a_fwd_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && fwd) |=> (rd_data_o == $past(wr_data_i)))
    else $error("forwarded read data mismatch");

  a_wr_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> (valid_q != '0))
    else $error("write left no entry valid");
`endif

endmodule

// ----- hdl/spb_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_serializer
// Packet register and byte counter; sends one packet byte per transaction,
// or a single flagged result for a bad servo id.
// ----------------------------------------------------------------------------
module spb_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  spb_pkg::pkt_t      pkt_i,
  output logic               free_o,
  output logic               out_valid_o,
  output spb_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);
  import spb_pkg::*;

  logic     valid_q;
  pkt_t     pkt_q;
  pkt_idx_e idx_q;
  logic     last;
  logic     fire;
  logic [7:0] byte_sel;

  assign last   = pkt_q.bad || (idx_q == IDX_CHK);
  assign fire   = valid_q && !out_stall_i;
  assign free_o = !valid_q || (fire && last);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pkt_q <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= IDX_HDR0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= IDX_HDR0;
    end else if (fire && last) begin
      valid_q <= 1'b0;
      idx_q   <= IDX_HDR0;
    end else if (fire) begin
      idx_q <= pkt_idx_e'(idx_q + 4'd1);
    end
  end

  always_comb begin
    case (idx_q)
      IDX_HDR0, IDX_HDR1: byte_sel = HDR_BYTE;
      IDX_ID:             byte_sel = pkt_q.id;
      IDX_LEN:            byte_sel = PKT_LENGTH;
      IDX_INSTR:          byte_sel = INSTR_WRITE;
      IDX_ADDR:           byte_sel = ADDR_GOAL_POS;
      IDX_POS_LO:         byte_sel = pkt_q.pos[7:0];
      IDX_POS_HI:         byte_sel = {6'd0, pkt_q.pos[9:8]};
      IDX_SPD_LO:         byte_sel = pkt_q.spd[7:0];
      IDX_SPD_HI:         byte_sel = {6'd0, pkt_q.spd[9:8]};
      IDX_CHK:            byte_sel = pkt_q.chk;
      default:            byte_sel = 8'd0;
    endcase
  end

  assign out_valid_o            = valid_q;
  assign out_item_o.packet_byte = pkt_q.bad ? 8'd0 : byte_sel;
  assign out_item_o.last_byte   = last;
  assign out_item_o.bad_id      = pkt_q.bad;

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= IDX_CHK))
    else $error("byte index past checksum");

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && pkt_q.bad) |-> (idx_q == IDX_HDR0))
    else $error("bad id result is not a single transaction");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && !load_i) |=> !valid_q)
    else $error("serializer busy after last byte");
`endif

endmodule

// ----- bench/tb_servo_position_packet_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_position_packet_builder_core
// Self-checking bench: drives servo commands with random gaps and output
// stalls, keeps its own goal positions and position step, builds the expected
// write packet bytes for each accepted command and checks every output byte.
// ----------------------------------------------------------------------------
module tb_servo_position_packet_builder_core;
  import spb_pkg::*;

  localparam int unsigned NUM_SERVOS = DEF_NUM_SERVOS;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [POS_W-1:0]  cfg_data_i = '0;

  logic [POS_W-1:0]  goal_pos [NUM_SERVOS];
  logic [POS_W-1:0]  step_reg;
  out_item_t         expected_bytes [$];
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                idle_on = 1'b1;

  servo_position_packet_builder_core #(
    .NUM_SERVOS(NUM_SERVOS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // update the goal position and queue the packet bytes for one command
  task automatic build_packet(input in_item_t cmd);
    logic [POS_W:0]   moved;
    logic [POS_W-1:0] pos;
    logic [7:0]       pkt [11];
    logic [7:0]       sum;
    out_item_t        ob;
    if (cmd.servo_id == 8'd0 || cmd.servo_id > NUM_SERVOS) begin
      ob.packet_byte = 8'h00;
      ob.last_byte   = 1'b1;
      ob.bad_id      = 1'b1;
      expected_bytes.push_back(ob);
      return;
    end
    pos = goal_pos[cmd.servo_id - 1];
    case (dir_e'(cmd.direction))
      DIR_REVERSE: begin
        pos = (pos >= step_reg) ? pos - step_reg : '0;
      end
      DIR_FORWARD: begin
        moved = {1'b0, pos} + {1'b0, step_reg};
        pos = (moved > {1'b0, POS_MAX}) ? POS_MAX : moved[POS_W-1:0];
      end
      default: begin
      end
    endcase
    goal_pos[cmd.servo_id - 1] = pos;
    pkt[IDX_HDR0]   = HDR_BYTE;
    pkt[IDX_HDR1]   = HDR_BYTE;
    pkt[IDX_ID]     = cmd.servo_id;
    pkt[IDX_LEN]    = PKT_LENGTH;
    pkt[IDX_INSTR]  = INSTR_WRITE;
    pkt[IDX_ADDR]   = ADDR_GOAL_POS;
    pkt[IDX_POS_LO] = pos[7:0];
    pkt[IDX_POS_HI] = {6'd0, pos[9:8]};
    pkt[IDX_SPD_LO] = cmd.speed[7:0];
    pkt[IDX_SPD_HI] = {6'd0, cmd.speed[9:8]};
    sum = '0;
    for (int i = IDX_ID; i <= IDX_SPD_HI; i++) sum += pkt[i];
    pkt[IDX_CHK] = HDR_BYTE - sum;
    for (int i = 0; i < 11; i++) begin
      ob.packet_byte = pkt[i];
      ob.last_byte   = (i == IDX_CHK);
      ob.bad_id      = 1'b0;
      expected_bytes.push_back(ob);
    end
  endtask

  task automatic send_command(input logic [7:0] id, input dir_e dir, input logic [9:0] spd);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i.servo_id  = id;
    in_item_i.direction = dir;
    in_item_i.speed     = spd;
    do @(posedge clk_i); while (in_stall_o);
    build_packet(in_item_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_step(input logic [POS_W-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    step_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_reset_positions();
    for (int s = 1; s <= NUM_SERVOS; s++) begin
      send_command(s[7:0], (s % 2) ? DIR_HOLD : DIR_HOLD_ALT,
                   (s % 2) ? 10'd0 : 10'd1023);
    end
  endtask

  task automatic test_bad_ids();
    send_command(8'd0, DIR_FORWARD, 10'd1023);
    send_command(8'(NUM_SERVOS + 1), DIR_REVERSE, 10'd0);
    send_command(8'd128, DIR_FORWARD, 10'h2AA);
    send_command(8'd255, DIR_HOLD, 10'h155);
  endtask

  task automatic test_directions();
    send_command(8'd1, DIR_REVERSE, 10'd1023);
    send_command(8'd1, DIR_HOLD, 10'd0);
    send_command(8'd1, DIR_FORWARD, 10'h155);
    send_command(8'd1, DIR_HOLD_ALT, 10'h2AA);
  endtask

  task automatic test_clamping();
    write_step(10'd1023);
    send_command(8'd2, DIR_FORWARD, 10'd7);
    send_command(8'd2, DIR_REVERSE, 10'd300);
    send_command(8'd2, DIR_REVERSE, 10'd512);
    write_step(10'd0);
    send_command(8'd3, DIR_FORWARD, 10'd1);
    send_command(8'd3, DIR_REVERSE, 10'd2);
  endtask

  task automatic test_random(input int unsigned count);
    logic [7:0] id;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) id = 8'($urandom_range(1, NUM_SERVOS));
      else if ($urandom_range(3) == 0) id = 8'd0;
      else id = 8'($urandom_range(NUM_SERVOS + 1, 255));
      send_command(id, dir_e'($urandom_range(3)), 10'($urandom_range(1023)));
    end
  endtask

  // output stall
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 17);
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: packet_byte %h last_byte %b bad_id %b",
               out_item_o.packet_byte, out_item_o.last_byte, out_item_o.bad_id);
        error_count++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_item_o.packet_byte !== exp_b.packet_byte) begin
          $error("packet_byte: expected %h, actual %h", exp_b.packet_byte,
                 out_item_o.packet_byte);
          error_count++;
        end
        if (out_item_o.last_byte !== exp_b.last_byte) begin
          $error("last_byte: expected %b, actual %b", exp_b.last_byte, out_item_o.last_byte);
          error_count++;
        end
        if (out_item_o.bad_id !== exp_b.bad_id) begin
          $error("bad_id: expected %b, actual %b", exp_b.bad_id, out_item_o.bad_id);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < NUM_SERVOS; s++) goal_pos[s] = POS_RESET;
    step_reg = STEP_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_positions();
    test_bad_ids();
    test_directions();
    test_clamping();

    write_step(10'($urandom_range(1, 200)));
    test_random(90);
    write_step(10'd1023);
    test_random(40);
    write_step(10'd0);
    idle_on = 1'b0;
    test_random(80);
    idle_on = 1'b1;
    write_step(10'($urandom_range(1023)));
    test_random(70);
    write_step(10'($urandom_range(1, 64)));
    test_random(70);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
